/* rtl/etsi_pkg.sv */
// Shared types, codes and valve patterns of the engine test sequence interlock.
package etsi_pkg;

  localparam int VALVE_COUNT  = 10;
  localparam int PYRO_COUNT   = 2;
  localparam int SAFETY_COUNT = 6;
  localparam int VALVE_W      = 2 * VALVE_COUNT;

  // Command codes carried in the action field
  typedef enum logic [3:0] {
    ACT_DEBUG          = 4'd0,
    ACT_PASSIVE        = 4'd1,
    ACT_TEST           = 4'd2,
    ACT_ABORT          = 4'd3,
    ACT_VENT           = 4'd4,
    ACT_HP_ARM         = 4'd5,
    ACT_HP_PRESSURIZE  = 4'd6,
    ACT_TANK_ARM       = 4'd7,
    ACT_TANK_PRESSURIZE = 4'd8,
    ACT_FIRE_ARM       = 4'd9,
    ACT_FIRE           = 4'd10,
    ACT_MANUAL_VALVE   = 4'd11,
    ACT_MANUAL_SAFETY  = 4'd12,
    ACT_HALT_CHECK     = 4'd13
  } action_t;

  typedef enum logic [3:0] {
    ST_PASSIVE    = 4'd0,
    ST_TEST       = 4'd1,
    ST_HP_ARM     = 4'd2,
    ST_HP_PRESS   = 4'd3,
    ST_TANK_ARM   = 4'd4,
    ST_TANK_PRESS = 4'd5,
    ST_FIRE_ARMED = 4'd6,
    ST_FIRE       = 4'd7,
    ST_ABORT      = 4'd8,
    ST_VENT       = 4'd9,
    ST_DEBUG      = 4'd10
  } seq_state_t;

  localparam logic [1:0] VLV_CLOSE = 2'd0;
  localparam logic [1:0] VLV_OPEN  = 2'd1;

  // Valve patterns, two bits per valve, valve 0 lowest
  localparam logic [VALVE_W-1:0] PAT_ALL_CLOSED = 20'h00000;
  localparam logic [VALVE_W-1:0] PAT_VENT       = 20'h01454;
  localparam logic [VALVE_W-1:0] PAT_HP_OPEN    = 20'h00001;
  localparam logic [VALVE_W-1:0] PAT_TANK_PRESS = 20'h01041;
  localparam logic [VALVE_W-1:0] PAT_FIRE       = 20'hA1041;

  // Main valves closed by a halt check
  localparam int MAIN_VALVE_LO = 8;

  typedef struct packed {
    logic [3:0] action;
    logic [3:0] target_index;
    logic       set_on;
  } in_item_t;

  typedef struct packed {
    logic [3:0]              sequence_state;
    logic [VALVE_W-1:0]      valve_commands;
    logic [PYRO_COUNT-1:0]   pyro_fire;
    logic [SAFETY_COUNT-1:0] safety_enables;
    logic                    halt_active;
    logic                    applied;
  } out_item_t;

  // Interlock state carried between items
  typedef struct packed {
    seq_state_t              seq;
    logic [VALVE_W-1:0]      valves;
    logic [PYRO_COUNT-1:0]   pyro;
    logic [SAFETY_COUNT-1:0] safety;
    logic                    halt;
  } ilk_state_t;

  localparam ilk_state_t ILK_RESET = '{
    seq:    ST_PASSIVE,
    valves: PAT_ALL_CLOSED,
    pyro:   '0,
    safety: '0,
    halt:   1'b0
  };

endpackage

/* rtl/etsi_step_logic.sv */
// Command decode and state gating: next interlock state for one item.
module etsi_step_logic (
  input  etsi_pkg::in_item_t   cmd,
  input  etsi_pkg::ilk_state_t cur,
  output etsi_pkg::ilk_state_t nxt,
  output logic                 applied
);
  import etsi_pkg::*;

  logic                    step_gate;
  logic [VALVE_W-1:0]      step_pat;
  logic                    step_pyro;
  seq_state_t              step_state;
  logic                    is_step;

  // Gate, pattern and target state of the arm/pressurize/fire steps
  always_comb begin
    is_step    = 1'b1;
    step_gate  = 1'b0;
    step_pat   = PAT_ALL_CLOSED;
    step_pyro  = 1'b0;
    step_state = cur.seq;
    case (cmd.action)
      ACT_HP_ARM: begin
        step_gate  = (cur.seq == ST_PASSIVE);
        step_state = ST_HP_ARM;
      end
      ACT_HP_PRESSURIZE: begin
        step_gate  = (cur.seq == ST_HP_ARM) || (cur.seq == ST_TANK_ARM);
        step_pat   = PAT_HP_OPEN;
        step_state = ST_HP_PRESS;
      end
      ACT_TANK_ARM: begin
        step_gate  = (cur.seq == ST_HP_PRESS);
        step_pat   = PAT_HP_OPEN;
        step_state = ST_TANK_ARM;
      end
      ACT_TANK_PRESSURIZE: begin
        step_gate  = (cur.seq == ST_TANK_ARM);
        step_pat   = PAT_TANK_PRESS;
        step_state = ST_TANK_PRESS;
      end
      ACT_FIRE_ARM: begin
        step_gate  = (cur.seq == ST_TANK_PRESS);
        step_pat   = PAT_TANK_PRESS;
        step_state = ST_FIRE_ARMED;
      end
      ACT_FIRE: begin
        step_gate  = (cur.seq == ST_FIRE_ARMED);
        step_pat   = PAT_FIRE;
        step_pyro  = 1'b1;
        step_state = ST_FIRE;
      end
      default: is_step = 1'b0;
    endcase
  end

  always_comb begin
    nxt     = cur;
    applied = 1'b0;
    case (cmd.action)
      ACT_DEBUG: begin
        nxt.seq = ST_DEBUG;
        applied = 1'b1;
      end
      ACT_PASSIVE: begin
        nxt.seq    = ST_PASSIVE;
        nxt.valves = PAT_ALL_CLOSED;
        nxt.pyro   = '0;
        nxt.halt   = 1'b0;
        applied    = 1'b1;
      end
      ACT_TEST: begin
        nxt.seq = ST_TEST;
        applied = 1'b1;
      end
      ACT_ABORT: begin
        nxt.seq  = ST_ABORT;
        nxt.halt = 1'b1;
        applied  = 1'b1;
      end
      ACT_VENT: begin
        nxt.seq    = ST_VENT;
        nxt.valves = PAT_VENT;
        nxt.pyro   = '0;
        applied    = 1'b1;
      end
      ACT_MANUAL_VALVE: begin
        if (cur.seq == ST_TEST) begin
          for (int i = 0; i < VALVE_COUNT; i++) begin
            if (cmd.target_index == 4'(i)) begin
              nxt.valves[2*i +: 2] = cmd.set_on ? VLV_OPEN : VLV_CLOSE;
              applied = 1'b1;
            end
          end
        end
      end
      ACT_MANUAL_SAFETY: begin
        if (cur.seq == ST_TEST) begin
          for (int i = 0; i < SAFETY_COUNT; i++) begin
            if (cmd.target_index == 4'(i)) begin
              nxt.safety[i] = cmd.set_on;
              applied = 1'b1;
            end
          end
        end
      end
      ACT_HALT_CHECK: begin
        if (cur.halt) begin
          nxt.valves[VALVE_W-1:2*MAIN_VALVE_LO] = '0;
          nxt.pyro = '0;
          applied  = 1'b1;
        end
      end
      default: begin
        // steps load their pattern only when the gate passes
        if (is_step && step_gate) begin
          nxt.seq    = step_state;
          nxt.valves = step_pat;
          nxt.pyro   = {PYRO_COUNT{step_pyro}};
          applied    = 1'b1;
        end
      end
    endcase
  end

endmodule

/* rtl/etsi_out_reg.sv */
// Result register with valid/ready handshake toward the consumer.
module etsi_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  etsi_pkg::out_item_t load_item,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output etsi_pkg::out_item_t out_item
);
  import etsi_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/engine_test_sequence_interlock_unit.sv */
// Engine test sequence interlock: command register, gated state update, result register.
// Path: an accepted item waits in the command register and moves into the result register
//   when that has room; the state update sits between the two registers.
// Throughput: one item per cycle while the consumer keeps out_ready high.
// Reset (rst_n low, synchronous): state passive, all valves closed, pyros off,
//   safety enables off, halt latch clear, both registers empty.
module engine_test_sequence_interlock_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  etsi_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output etsi_pkg::out_item_t out_item
);
  import etsi_pkg::*;

  // Input register: holds one command until the result register takes it
  logic       cmd_valid_r, cmd_valid_nxt;
  in_item_t   cmd_r;

  // Interlock state, updated once per processed item
  ilk_state_t ilk_r;
  ilk_state_t ilk_nxt;
  logic       step_applied;

  out_item_t  res_item;
  logic       res_can_load;
  logic       advance;

  // Advance the command whenever the result register has room.
  assign advance  = cmd_valid_r && res_can_load;
  // Take a new command when the input register is empty or drains this cycle.
  assign in_ready = !cmd_valid_r || advance;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (in_valid && in_ready) begin
      cmd_valid_nxt = 1'b1;
    end else if (advance) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_item;
    end
  end

  etsi_step_logic u_step (
    .cmd     (cmd_r),
    .cur     (ilk_r),
    .nxt     (ilk_nxt),
    .applied (step_applied)
  );

  // Commit the new state only when the item moves on to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ilk_r <= ILK_RESET;
    end else if (advance) begin
      ilk_r <= ilk_nxt;
    end
  end

  // Result reports the state after the command is applied
  always_comb begin
    res_item.sequence_state = ilk_nxt.seq;
    res_item.valve_commands = ilk_nxt.valves;
    res_item.pyro_fire      = ilk_nxt.pyro;
    res_item.safety_enables = ilk_nxt.safety;
    res_item.halt_active    = ilk_nxt.halt;
    res_item.applied        = step_applied;
  end

  etsi_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .load_item (res_item),
    .can_load  (res_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* rtl/etsi_checker.sv */
// Port-level checker for the interlock unit and its bind.
module etsi_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input etsi_pkg::out_item_t out_item
);
  import etsi_pkg::*;

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // Abort state always comes with the halt latch set.
  a_abort_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.sequence_state == ST_ABORT) |-> out_item.halt_active)
    else $error("abort state without halt latch");

  // Passive state: everything closed, pyros off, latch clear.
  a_passive_safe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.sequence_state == ST_PASSIVE) |->
      (out_item.valve_commands == PAT_ALL_CLOSED) && (out_item.pyro_fire == '0) &&
      !out_item.halt_active)
    else $error("passive state not safe");

  // Fire state: fire pattern loaded, both pyros commanded, latch clear.
  a_fire_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.sequence_state == ST_FIRE) |->
      (out_item.valve_commands == PAT_FIRE) && (out_item.pyro_fire == '1) &&
      !out_item.halt_active)
    else $error("fire state with wrong outputs");

endmodule

bind engine_test_sequence_interlock_unit etsi_checker u_etsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

/* bench/engine_test_sequence_interlock_checker.sv */
// Checker for the engine test sequence interlock: command prediction and result comparison.
`timescale 1ns / 1ps

module engine_test_sequence_interlock_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  etsi_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  etsi_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_results,
  output int                  applied_count,
  output int                  checked_count
);
  import etsi_pkg::*;

  // Predicted interlock state
  seq_state_t              seq_now;
  logic [VALVE_W-1:0]      valve_word;
  logic [PYRO_COUNT-1:0]   pyro_bits;
  logic [SAFETY_COUNT-1:0] safety_bits;
  logic                    halt_bit;

  out_item_t expected_results[$];
  int        fails;
  int        applied_total;
  int        checked_total;

  task automatic report_mismatch(input string what, input logic [33:0] got,
                                 input logic [33:0] want);
    $display("%0t ns: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fails++;
  endtask

  task automatic check_field(input string what, input logic [33:0] got,
                             input logic [33:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Sequence step: load pattern and advance only when the gate holds
  task automatic take_step(input logic gate, input logic [VALVE_W-1:0] pat,
                           input logic fire, input seq_state_t nxt, output logic ok);
    ok = gate;
    if (gate) begin
      valve_word = pat;
      pyro_bits  = {PYRO_COUNT{fire}};
      seq_now    = nxt;
    end
  endtask

  task automatic apply_command(input in_item_t cmd, output out_item_t res);
    logic ok;
    ok = 1'b0;
    case (cmd.action)
      ACT_DEBUG: begin
        seq_now = ST_DEBUG;
        ok = 1'b1;
      end
      ACT_PASSIVE: begin
        valve_word = PAT_ALL_CLOSED;
        pyro_bits  = '0;
        seq_now    = ST_PASSIVE;
        halt_bit   = 1'b0;
        ok = 1'b1;
      end
      ACT_TEST: begin
        seq_now = ST_TEST;
        ok = 1'b1;
      end
      ACT_ABORT: begin
        halt_bit = 1'b1;
        seq_now  = ST_ABORT;
        ok = 1'b1;
      end
      ACT_VENT: begin
        valve_word = PAT_VENT;
        pyro_bits  = '0;
        seq_now    = ST_VENT;
        ok = 1'b1;
      end
      ACT_HP_ARM:
        take_step(seq_now == ST_PASSIVE, PAT_ALL_CLOSED, 1'b0, ST_HP_ARM, ok);
      ACT_HP_PRESSURIZE:
        take_step(seq_now == ST_HP_ARM || seq_now == ST_TANK_ARM, PAT_HP_OPEN, 1'b0,
                  ST_HP_PRESS, ok);
      ACT_TANK_ARM:
        take_step(seq_now == ST_HP_PRESS, PAT_HP_OPEN, 1'b0, ST_TANK_ARM, ok);
      ACT_TANK_PRESSURIZE:
        take_step(seq_now == ST_TANK_ARM, PAT_TANK_PRESS, 1'b0, ST_TANK_PRESS, ok);
      ACT_FIRE_ARM:
        take_step(seq_now == ST_TANK_PRESS, PAT_TANK_PRESS, 1'b0, ST_FIRE_ARMED, ok);
      ACT_FIRE:
        take_step(seq_now == ST_FIRE_ARMED, PAT_FIRE, 1'b1, ST_FIRE, ok);
      ACT_MANUAL_VALVE:
        if (seq_now == ST_TEST && cmd.target_index < VALVE_COUNT) begin
          valve_word[2*cmd.target_index +: 2] = cmd.set_on ? VLV_OPEN : VLV_CLOSE;
          ok = 1'b1;
        end
      ACT_MANUAL_SAFETY:
        if (seq_now == ST_TEST && cmd.target_index < SAFETY_COUNT) begin
          safety_bits[cmd.target_index] = cmd.set_on;
          ok = 1'b1;
        end
      ACT_HALT_CHECK:
        if (halt_bit) begin
          valve_word[2*MAIN_VALVE_LO +: 4] = {VLV_CLOSE, VLV_CLOSE};
          pyro_bits = '0;
          ok = 1'b1;
        end
      default: ;
    endcase
    res.sequence_state = seq_now;
    res.valve_commands = valve_word;
    res.pyro_fire      = pyro_bits;
    res.safety_enables = safety_bits;
    res.halt_active    = halt_bit;
    res.applied        = ok;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t pred;
    if (!rst_n) begin
      seq_now     = ST_PASSIVE;
      valve_word  = PAT_ALL_CLOSED;
      pyro_bits   = '0;
      safety_bits = '0;
      halt_bit    = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_item, '0);
        end else begin
          want = expected_results.pop_front();
          check_field("sequence_state", out_item.sequence_state, want.sequence_state);
          check_field("valve_commands", out_item.valve_commands, want.valve_commands);
          check_field("pyro_fire", out_item.pyro_fire, want.pyro_fire);
          check_field("safety_enables", out_item.safety_enables, want.safety_enables);
          check_field("halt_active", out_item.halt_active, want.halt_active);
          check_field("applied", out_item.applied, want.applied);
          checked_total++;
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_item, pred);
        expected_results.push_back(pred);
        applied_total += pred.applied;
      end
    end
    fail_count      <= fails;
    pending_results <= expected_results.size();
    applied_count   <= applied_total;
    checked_count   <= checked_total;
  end

endmodule

/* bench/tb_engine_test_sequence_interlock_unit.sv */
// Top of the interlock testbench: clock, reset, command stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_engine_test_sequence_interlock_unit;
  import etsi_pkg::*;

  // Action code outside the defined set; the block must ignore it
  localparam logic [3:0] ACT_UNUSED_TOP = 4'd15;

  // Long output stall: enough to fill both internal registers and back up the input
  localparam int STALL_CYCLES = 150;
  // No correct run goes this long without an item moving on either channel
  localparam int QUIET_LIMIT  = 1000;
  // Least number of input items to send in each idle phase
  localparam int PHASE_ITEMS  = 158;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int fail_count;
  int pending_results;
  int applied_count;
  int checked_count;

  int sender_idle_pct   = 21;
  int receiver_idle_pct = 57;
  bit long_stall        = 1'b0;
  int quiet_cycles      = 0;
  int commands_sent     = 0;
  int burst_len;
  int phase_end;

  engine_test_sequence_interlock_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  engine_test_sequence_interlock_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .applied_count   (applied_count),
    .checked_count   (checked_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one command item. Idle gaps come first, so valid never drops once raised;
  // hold valid and payload until the item is taken.
  task automatic send_cmd(input logic [3:0] act, input logic [3:0] idx, input logic on);
    in_item_t cmd;
    cmd.action       = act;
    cmd.target_index = idx;
    cmd.set_on       = on;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk); while (!in_ready);
    commands_sent++;
  endtask

  // Fully random item: any action code, including the unused ones, any index
  task automatic send_noise();
    send_cmd(4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)));
  endtask

  // One step of a well-formed sequence; now and then slip a stray item in front of it.
  // Index and set_on are don't-care for these actions, so randomize them.
  task automatic send_step(input action_t act);
    if ($urandom_range(11) == 0) send_noise();
    send_cmd(act, 4'($urandom_range(15)), 1'($urandom_range(1)));
  endtask

  // Manual target: mostly in range, sometimes anywhere in the 4-bit field
  function automatic logic [3:0] pick_index(input int count);
    if ($urandom_range(3) == 0) return 4'($urandom_range(15));
    return 4'($urandom_range(count - 1));
  endfunction

  // Drop valid and hold off until every predicted result has come back.
  // The extra edge lets the checker count an item accepted at this edge.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off counted here while the sender keeps going
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        long_stall = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Start with the output held off so the directed items back up into the block
    long_stall = 1'b1;

    // Directed: walk the full firing chain, including the loop back from tank arm
    send_cmd(ACT_HP_ARM, 4'd0, 1'b0);
    send_cmd(ACT_HP_PRESSURIZE, 4'd0, 1'b0);
    send_cmd(ACT_TANK_ARM, 4'd0, 1'b0);
    send_cmd(ACT_HP_PRESSURIZE, 4'd15, 1'b1);
    send_cmd(ACT_TANK_ARM, 4'd0, 1'b0);
    send_cmd(ACT_TANK_PRESSURIZE, 4'd0, 1'b0);
    send_cmd(ACT_FIRE_ARM, 4'd0, 1'b0);
    send_cmd(ACT_FIRE, 4'd0, 1'b0);
    // Halt check with the latch clear does nothing; after abort it closes mains, kills pyros
    send_cmd(ACT_HALT_CHECK, 4'd0, 1'b0);
    send_cmd(ACT_ABORT, 4'd0, 1'b0);
    send_cmd(ACT_HALT_CHECK, 4'd0, 1'b0);
    // Step out of order is refused; manual command outside test state is ignored
    send_cmd(ACT_FIRE, 4'd0, 1'b0);
    send_cmd(ACT_MANUAL_VALVE, 4'd3, 1'b1);
    send_cmd(ACT_PASSIVE, 4'd0, 1'b0);
    send_cmd(ACT_TEST, 4'd0, 1'b0);
    // Manual valve and safety commands at both ends of their range; valve 15 and safety 6 lie past it
    send_cmd(ACT_MANUAL_VALVE, 4'd9, 1'b1);
    send_cmd(ACT_MANUAL_VALVE, 4'd15, 1'b1);
    send_cmd(ACT_MANUAL_VALVE, 4'd0, 1'b1);
    send_cmd(ACT_MANUAL_SAFETY, 4'd5, 1'b1);
    send_cmd(ACT_MANUAL_SAFETY, 4'd6, 1'b1);
    send_cmd(ACT_MANUAL_SAFETY, 4'd0, 1'b1);
    send_cmd(ACT_VENT, 4'd0, 1'b0);
    send_cmd(ACT_DEBUG, 4'd0, 1'b0);
    send_cmd(ACT_UNUSED_TOP, 4'd15, 1'b1);
    send_cmd(ACT_HP_ARM, 4'd0, 1'b0);
    wait_results_drained();

    // Random: three idle mixes, each run for at least PHASE_ITEMS items
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 21;
          receiver_idle_pct = 57;
        end
        1: begin
          sender_idle_pct   = 57;
          receiver_idle_pct = 21;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      phase_end = commands_sent + PHASE_ITEMS;
      while (commands_sent < phase_end) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // Firing run; skip passive now and then so the first arm can be refused
            if ($urandom_range(3) != 0) send_step(ACT_PASSIVE);
            send_step(ACT_HP_ARM);
            send_step(ACT_HP_PRESSURIZE);
            send_step(ACT_TANK_ARM);
            if ($urandom_range(2) == 0) begin
              send_step(ACT_HP_PRESSURIZE);
              send_step(ACT_TANK_ARM);
            end
            send_step(ACT_TANK_PRESSURIZE);
            send_step(ACT_FIRE_ARM);
            send_step(ACT_FIRE);
            case ($urandom_range(2))
              0: begin
                send_step(ACT_ABORT);
                send_step(ACT_HALT_CHECK);
              end
              1: send_step(ACT_VENT);
              default: send_step(ACT_HALT_CHECK);
            endcase
          end
          4, 5, 6: begin
            // Test session: a burst of manual valve and safety commands
            send_step(ACT_TEST);
            burst_len = $urandom_range(8, 3);
            repeat (burst_len) begin
              if ($urandom_range(1) == 1)
                send_cmd(ACT_MANUAL_VALVE, pick_index(VALVE_COUNT), 1'($urandom_range(1)));
              else
                send_cmd(ACT_MANUAL_SAFETY, pick_index(SAFETY_COUNT), 1'($urandom_range(1)));
            end
          end
          7: begin
            // Abort and halt handling around a stray command
            send_step(ACT_ABORT);
            send_step(ACT_HALT_CHECK);
            send_noise();
            send_step(ACT_HALT_CHECK);
            send_step(ACT_PASSIVE);
          end
          default: repeat (4) send_noise();
        endcase
      end
      wait_results_drained();
    end

    // Let the pipeline settle past its two-register latency
    repeat (4) @(posedge clk);

    $display("Coverage: %0d commands sent, %0d took effect, %0d results compared.",
             commands_sent, applied_count, checked_count);
    $display("Covered: firing chain, test-state manual control, halt checks, stray codes; "
             , "three idle mixes and a long output hold-off.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/etsi_pkg.sv
rtl/etsi_step_logic.sv
rtl/etsi_out_reg.sv
rtl/engine_test_sequence_interlock_unit.sv
rtl/etsi_checker.sv
bench/engine_test_sequence_interlock_checker.sv
bench/tb_engine_test_sequence_interlock_unit.sv
